// ===== hdl/unct_pkg.sv =====
// shared types and constants for the unix nanoseconds to calendar converter
`timescale 1ns / 1ps
`default_nettype none
package unct_pkg;

	typedef logic [11:0] year_t;
	typedef logic [3:0]  month_t;
	typedef logic [4:0]  mday_t;
	typedef logic [4:0]  hour_t;
	typedef logic [5:0]  minute_t;
	typedef logic [5:0]  second_t;
	typedef logic [29:0] nano_t;
	typedef logic [36:0] secs_t;
	typedef logic [20:0] dnum_t;
	typedef logic [16:0] sod_t;

	// one billion split as 2^9 * 5^9
	localparam logic [20:0] SUB_DIV      = 21'd1953125;
	localparam logic [63:0] SUB_RCP_FULL = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1953125;
	localparam logic [43:0] SUB_RCP      = 44'(SUB_RCP_FULL);

	// epoch and civil shift folded into one offset, keeps seconds non-negative
	localparam logic [36:0] SEC_OFS    = 37'd52938663164;
	localparam logic [29:0] FRAC_SPLIT = 30'd854775808;
	localparam logic [29:0] FRAC_WRAP  = 30'd145224192;

	// 86400 split as 2^7 * 675
	localparam logic [9:0]  DAY_DIV = 10'd675;
	localparam logic [30:0] DAY_RCP = 31'(((64'd1 << 40) + 64'd674) / 64'd675);

	localparam logic [20:0] ERA_DAYS = 21'd146097;
	localparam int unsigned ERA_MAX  = 5;
	localparam logic [17:0] CENT_DAYS = 18'd36524;
	localparam logic [17:0] ERA_LAST  = 18'd146096;

	localparam logic [18:0] D1460_RCP = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] YEAR_RCP  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [11:0] MP_RCP    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
	localparam logic [22:0] MP_RCP5   = 23'(64'd5 * 64'(MP_RCP));
	localparam logic [22:0] MP_RCP2   = 23'(64'd2 * 64'(MP_RCP));

	localparam logic [17:0] HOUR_RCP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [16:0] HOUR_SEC = 17'd3600;
	localparam logic [12:0] MIN_RCP  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [11:0] MIN_SEC  = 12'd60;

endpackage
`default_nettype wire

// ===== hdl/unct_sec_split.sv =====
// floor split of signed nanoseconds into offset seconds and nanosecond fraction
`timescale 1ns / 1ps
`default_nettype none
module unct_sec_split (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld,
	input  logic [63:0]     unix_time_ns,
	output logic            secs_vld,
	output unct_pkg::secs_t secs,
	output unct_pkg::nano_t frac
);
	import unct_pkg::*;

	logic [63:0] biased;
	logic [54:0] u;

	logic [49:0] pp_ll_s1, pp_lh_s1;
	logic [48:0] pp_hl_s1, pp_hh_s1;
	logic [22:0] u23_s1;
	logic [8:0]  lo9_s1;
	logic        vld_s1;

	logic [72:0] a_s2;
	logic [71:0] b_s2;
	logic [22:0] u23_s2;
	logic [8:0]  lo9_s2;
	logic        vld_s2;

	logic [99:0] total;
	logic [34:0] q_s3;
	logic [22:0] u23_s3;
	logic [8:0]  lo9_s3;
	logic        vld_s3;

	logic [45:0] qd_prod;
	logic [34:0] q_s4;
	logic [22:0] r_s4;
	logic [8:0]  lo9_s4;
	logic        vld_s4;

	logic        r_over;
	logic [22:0] r_fix;
	logic [34:0] qb_s5;
	logic [29:0] rb_s5;
	logic        vld_s5;

	logic        borrow;
	secs_t       secs_s6;
	nano_t       frac_s6;
	logic        vld_s6;

	// input plus 2^63 as unsigned
	assign biased  = {~unix_time_ns[63], unix_time_ns[62:0]};
	assign u       = biased[63:9];
	assign total   = 100'(a_s2) + {b_s2, 28'd0};
	assign qd_prod = 46'(q_s3[22:0]) * 46'(SUB_DIV);
	assign r_over  = (r_s4 >= 23'(SUB_DIV));
	assign r_fix   = r_over ? r_s4 - 23'(SUB_DIV) : r_s4;
	assign borrow  = (rb_s5 < FRAC_SPLIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// partial products of the reciprocal multiply
			pp_ll_s1 <= 50'(u[27:0]) * 50'(SUB_RCP[21:0]);
			pp_lh_s1 <= 50'(u[27:0]) * 50'(SUB_RCP[43:22]);
			pp_hl_s1 <= 49'(u[54:28]) * 49'(SUB_RCP[21:0]);
			pp_hh_s1 <= 49'(u[54:28]) * 49'(SUB_RCP[43:22]);
			u23_s1   <= u[22:0];
			lo9_s1   <= biased[8:0];

			a_s2   <= 73'(pp_ll_s1) + 73'({pp_lh_s1, 22'd0});
			b_s2   <= 72'(pp_hl_s1) + 72'({pp_hh_s1, 22'd0});
			u23_s2 <= u23_s1;
			lo9_s2 <= lo9_s1;

			// estimate is exact or one low
			q_s3   <= total[98:64];
			u23_s3 <= u23_s2;
			lo9_s3 <= lo9_s2;

			q_s4   <= q_s3;
			r_s4   <= u23_s3 - qd_prod[22:0];
			lo9_s4 <= lo9_s3;

			qb_s5 <= r_over ? q_s4 + 35'd1 : q_s4;
			rb_s5 <= {r_fix[20:0], lo9_s4};

			secs_s6 <= 37'(qb_s5) + SEC_OFS - 37'(borrow);
			frac_s6 <= borrow ? rb_s5 + FRAC_WRAP : rb_s5 - FRAC_SPLIT;
		end
	end

	assign secs_vld = vld_s6;
	assign secs     = secs_s6;
	assign frac     = frac_s6;

endmodule
`default_nettype wire

// ===== hdl/unct_day_split.sv =====
// split of offset seconds into day number and second of day
`timescale 1ns / 1ps
`default_nettype none
module unct_day_split (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld,
	input  unct_pkg::secs_t secs,
	output logic            day_vld,
	output unct_pkg::dnum_t z,
	output unct_pkg::sod_t  sod
);
	import unct_pkg::*;

	logic [29:0] t;
	logic [60:0] zp;
	logic [30:0] zd;

	dnum_t       z_s7;
	logic [9:0]  t10_s7;
	logic [6:0]  lo7_s7;
	logic        vld_s7;

	dnum_t       z_s8;
	sod_t        sod_s8;
	logic        vld_s8;

	assign t  = secs[36:7];
	assign zp = 61'(t) * 61'(DAY_RCP);
	assign zd = 31'(z_s7) * 31'(DAY_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s7   <= zp[60:40];
			t10_s7 <= t[9:0];
			lo7_s7 <= secs[6:0];

			z_s8   <= z_s7;
			sod_s8 <= {t10_s7 - zd[9:0], lo7_s7};
		end
	end

	assign day_vld = vld_s8;
	assign z       = z_s8;
	assign sod     = sod_s8;

endmodule
`default_nettype wire

// ===== hdl/unct_hms.sv =====
// hour, minute and second from the second of day
`timescale 1ns / 1ps
`default_nettype none
module unct_hms (
	input  logic              clk,
	input  logic              en,
	input  unct_pkg::sod_t    sod,
	output unct_pkg::hour_t   hour,
	output unct_pkg::minute_t minute,
	output unct_pkg::second_t second
);
	import unct_pkg::*;

	logic [34:0] hp;
	logic [16:0] hsec;
	logic [24:0] mp;
	logic [11:0] msec;

	hour_t   hour_s9, hour_s10, hour_s11, hour_s12;
	sod_t    sod_s9;
	logic [11:0] soh_s10, soh_s11;
	minute_t min_s11, min_s12;
	second_t sec_s12;
	logic [16:0] hms_s13, hms_s14, hms_s15, hms_s16;

	assign hp   = 35'(sod) * 35'(HOUR_RCP);
	assign hsec = 17'(hour_s9) * HOUR_SEC;
	assign mp   = 25'(soh_s10) * 25'(MIN_RCP);
	assign msec = 12'(min_s11) * MIN_SEC;

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s9 <= hp[33:29];
			sod_s9  <= sod;

			hour_s10 <= hour_s9;
			soh_s10  <= 12'(sod_s9 - hsec);

			hour_s11 <= hour_s10;
			soh_s11  <= soh_s10;
			min_s11  <= mp[23:18];

			hour_s12 <= hour_s11;
			min_s12  <= min_s11;
			sec_s12  <= 6'(soh_s11 - msec);

			// line up with the date path
			hms_s13 <= {hour_s12, min_s12, sec_s12};
			hms_s14 <= hms_s13;
			hms_s15 <= hms_s14;
			hms_s16 <= hms_s15;
		end
	end

	assign hour   = hms_s16[16:12];
	assign minute = hms_s16[11:6];
	assign second = hms_s16[5:0];

endmodule
`default_nettype wire

// ===== hdl/unct_civil.sv =====
// gregorian year, month and day from the shifted day number
`timescale 1ns / 1ps
`default_nettype none
module unct_civil (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld,
	input  unct_pkg::dnum_t  z,
	output logic             date_vld,
	output unct_pkg::year_t  year,
	output unct_pkg::month_t month,
	output unct_pkg::mday_t  day
);
	import unct_pkg::*;

	function automatic logic [8:0] month_off(input logic [3:0] mp);
		logic [8:0] off;
		unique case (mp)
			4'd0:    off = 9'd0;
			4'd1:    off = 9'd31;
			4'd2:    off = 9'd61;
			4'd3:    off = 9'd92;
			4'd4:    off = 9'd122;
			4'd5:    off = 9'd153;
			4'd6:    off = 9'd184;
			4'd7:    off = 9'd214;
			4'd8:    off = 9'd245;
			4'd9:    off = 9'd275;
			4'd10:   off = 9'd306;
			4'd11:   off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

	logic [2:0]  era_n;
	logic [36:0] ap;
	logic [2:0]  cent_n;
	logic [36:0] yp;
	logic [1:0]  yc_n;
	logic [17:0] ybase;
	logic [22:0] mpp;

	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;

	dnum_t       z_s9;
	logic [2:0]  era_s9, era_s10, era_s11, era_s12, era_s13, era_s14, era_s15;
	logic [17:0] doe_s10, doe_s11, doe_s12, doe_s13;
	logic [6:0]  a1_s11;
	logic [2:0]  cent_s11;
	logic        last_s11;
	logic [17:0] n_s12;
	logic [8:0]  yoe_s13, yoe_s14, yoe_s15;
	logic [8:0]  doy_s14, doy_s15;
	logic [3:0]  mp_s15;
	year_t       year_s16;
	month_t      month_s16;
	mday_t       day_s16;

	always_comb begin
		era_n = 3'd0;
		for (int k = 1; k <= ERA_MAX; k++) begin
			if (z >= 21'(k) * ERA_DAYS)
				era_n = era_n + 3'd1;
		end
	end

	always_comb begin
		cent_n = 3'd0;
		for (int k = 1; k <= 4; k++) begin
			if (doe_s10 >= 18'(k) * CENT_DAYS)
				cent_n = cent_n + 3'd1;
		end
	end

	always_comb begin
		yc_n = 2'd0;
		for (int k = 1; k <= 3; k++) begin
			if (yoe_s13 >= 9'(k * 100))
				yc_n = yc_n + 2'd1;
		end
	end

	assign ap    = 37'(doe_s10) * 37'(D1460_RCP);
	assign yp    = 37'(n_s12) * 37'(YEAR_RCP);
	assign ybase = 18'(yoe_s13) * 18'd365 + 18'(yoe_s13[8:2]) - 18'(yc_n);
	assign mpp   = 23'(doy_s14) * MP_RCP5 + MP_RCP2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else if (en) begin
			vld_s9  <= vld;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s9   <= z;
			era_s9 <= era_n;

			era_s10 <= era_s9;
			doe_s10 <= 18'(z_s9 - 21'(era_s9) * ERA_DAYS);

			era_s11  <= era_s10;
			doe_s11  <= doe_s10;
			a1_s11   <= ap[35:29];
			cent_s11 <= cent_n;
			last_s11 <= (doe_s10 == ERA_LAST);

			era_s12 <= era_s11;
			doe_s12 <= doe_s11;
			n_s12   <= doe_s11 - 18'(a1_s11) + 18'(cent_s11) - 18'(last_s11);

			era_s13 <= era_s12;
			doe_s13 <= doe_s12;
			yoe_s13 <= yp[35:27];

			era_s14 <= era_s13;
			yoe_s14 <= yoe_s13;
			doy_s14 <= 9'(doe_s13 - ybase);

			era_s15 <= era_s14;
			yoe_s15 <= yoe_s14;
			doy_s15 <= doy_s14;
			mp_s15  <= mpp[22:19];

			// march-based months; january and february belong to the next year
			year_s16  <= 12'(yoe_s15) + 12'(era_s15) * 12'd400 + 12'(mp_s15 >= 4'd10);
			month_s16 <= (mp_s15 < 4'd10) ? mp_s15 + 4'd3 : mp_s15 - 4'd9;
			day_s16   <= 5'(doy_s15 - month_off(mp_s15) + 9'd1);
		end
	end

	assign date_vld = vld_s16;
	assign year     = year_s16;
	assign month    = month_s16;
	assign day      = day_s16;

endmodule
`default_nettype wire

// ===== hdl/unix_nanos_to_calendar_fields.sv =====
// top level: unix nanoseconds to utc calendar fields
// Converts a signed 64-bit nanosecond count since 1970-01-01T00:00:00Z into
// UTC year, month, day, hour, minute, second and nanosecond fraction, with
// floor rounding so negative times give a non-negative fraction. The block
// takes one item per clock while the output is not stalled; the pipeline
// depth is set by the reciprocal multiply that divides by one billion
// (partial products, two adder stages, a back-multiply and a correction),
// the divide by 86400 and the era/year/month steps of the date.
// A stall on the output freezes the whole pipeline and is passed straight to
// the input stall; no item is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module unix_nanos_to_calendar_fields (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              time_valid,
	output logic              time_stall,
	input  logic [63:0]       unix_time_ns,
	output logic              cal_valid,
	input  logic              cal_stall,
	output unct_pkg::year_t   year,
	output unct_pkg::month_t  month,
	output unct_pkg::mday_t   day,
	output unct_pkg::hour_t   hour,
	output unct_pkg::minute_t minute,
	output unct_pkg::second_t second,
	output unct_pkg::nano_t   nanosecond
);
	import unct_pkg::*;

	logic  en;
	logic  secs_vld;
	secs_t secs;
	nano_t frac;
	logic  day_vld;
	dnum_t z;
	sod_t  sod;
	nano_t frac_sn [7:16];

	assign en         = !(cal_valid && cal_stall);
	assign time_stall = cal_valid && cal_stall;

	unct_sec_split u_sec (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld          (time_valid),
		.unix_time_ns (unix_time_ns),
		.secs_vld     (secs_vld),
		.secs         (secs),
		.frac         (frac)
	);

	unct_day_split u_day (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (secs_vld),
		.secs    (secs),
		.day_vld (day_vld),
		.z       (z),
		.sod     (sod)
	);

	unct_hms u_hms (
		.clk    (clk),
		.en     (en),
		.sod    (sod),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	unct_civil u_civil (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (day_vld),
		.z        (z),
		.date_vld (cal_valid),
		.year     (year),
		.month    (month),
		.day      (day)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			frac_sn[7] <= frac;
			for (int k = 8; k <= 16; k++)
				frac_sn[k] <= frac_sn[k - 1];
		end
	end

	assign nanosecond = frac_sn[16];

endmodule
`default_nettype wire

// ===== hdl/unct_chk.sv =====
// port-level checks for the calendar converter and its bind
`timescale 1ns / 1ps
`default_nettype none
module unct_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        time_stall,
	input logic        cal_valid,
	input logic        cal_stall,
	input logic [11:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second,
	input logic [29:0] nanosecond
);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && cal_stall |=> cal_valid && $stable(year) && $stable(month)
			&& $stable(day) && $stable(hour) && $stable(minute) && $stable(second)
			&& $stable(nanosecond))
		else $error("stalled item changed");

	a_input_stall: assert property (@(posedge clk) disable iff (!arst_n)
		time_stall |-> cal_valid && cal_stall)
		else $error("input stalled without output stall");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> year >= 12'd1677 && year <= 12'd2262 && month >= 4'd1
			&& month <= 4'd12 && day >= 5'd1 && hour <= 5'd23 && minute <= 6'd59
			&& second <= 6'd59 && nanosecond <= 30'd999999999)
		else $error("field out of range");

	a_month_len: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> !(month == 4'd2 && day > 5'd29)
			&& !((month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11)
			&& day > 5'd30))
		else $error("day beyond month length");

endmodule

bind unix_nanos_to_calendar_fields unct_chk u_unct_chk (.*);
`default_nettype wire
